@@ hdl/mcpf_pkg.sv @@
// ----------------------------------------------------------------------------
// mcpf_pkg: shared types, constants and functions of the pair finder
// Holds the stored entry layout, the register indexes and reset values, and
// the nibble mask helpers used by the matcher and the top level.
// ----------------------------------------------------------------------------
package mcpf_pkg;

    // Width of the structure counter kept with every stored entry.
    localparam int EPOCH_W = 8;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROUP_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAIN_MASK  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CIPHER_MASK = 2'd2;

    // Register reset values.
    localparam logic [15:0] GROUP_MASK_RST  = 16'h936C;
    localparam logic [15:0] PLAIN_MASK_RST  = 16'h4218;
    localparam logic [15:0] CIPHER_MASK_RST = 16'h6C93;

    // One stored pair together with its live marker.
    typedef struct packed {
        logic               valid;
        logic [EPOCH_W-1:0] epoch;
        logic [63:0]        plain;
        logic [63:0]        cipher;
    } entry_t;

    // Masks as seen by the matcher.
    typedef struct packed {
        logic [63:0] group_bits;
        logic [15:0] plain_nib;
        logic [15:0] cipher_nib;
    } masks_t;

    // Turn a nibble select mask into a bit mask.
    function automatic logic [63:0] nibble_expand(input logic [15:0] m);
        logic [63:0] r;
        r = '0;
        for (int i = 0; i < 16; i++) begin
            r[4*i +: 4] = {4{m[i]}};
        end
        return r;
    endfunction

    // True when every selected nibble of the two words differs.
    function automatic logic all_differ(input logic [63:0] x,
                                        input logic [63:0] y,
                                        input logic [15:0] m);
        logic [63:0] d;
        logic        ok;
        d  = x ^ y;
        ok = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (m[i] && (d[4*i +: 4] == 4'h0)) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

endpackage

@@ hdl/masked_collision_pair_finder_core.sv @@
// Requests are handled one at a time. The set index is the key masked when
// SETS is a power of two, otherwise a reciprocal multiply reduces it.
// The set scan reads one way at a time through one port.
// Reset: synchronous, active low; a clearing pass over SETS rounded up to a
// power of two times WAYS rounded up to a power of two entries (8192 by
// default) follows reset, and reruns every 256 structures.
// ----------------------------------------------------------------------------
// masked_collision_pair_finder_core: set-associative collision pair finder
// Stores plaintext/ciphertext pairs by a hash of their group nibbles and
// reports every earlier pair of the same set that forms a valid pair.
// ----------------------------------------------------------------------------
module masked_collision_pair_finder_core #(
    parameter int SETS = 1024,
    parameter int WAYS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    // Configuration write port.
    input  logic                           cfg_wen,
    input  logic [mcpf_pkg::CFG_IDX_W-1:0] cfg_idx,
    input  logic [15:0]                    cfg_wdata,

    // Input requests.
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_plain_word,
    input  logic [63:0] s_cipher_word,
    input  logic        s_first_of_structure,

    // Result requests.
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_stored_plain,
    output logic [63:0] m_stored_cipher,
    output logic [63:0] m_new_plain,
    output logic [63:0] m_new_cipher,
    output logic        m_overflow,
    output logic        m_last_of_run
);

    // Address layout: the set index in the high bits, the way in the low bits.
    localparam int SIDX_W = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WB     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ADDR_W = SIDX_W + WB;

    // Sequencer states, one-hot.
    typedef enum logic [8:0] {
        S_CLEAR    = 9'b000000001,
        S_IDLE     = 9'b000000010,
        S_HASH     = 9'b000000100,
        S_SCAN_RD  = 9'b000001000,
        S_SCAN_CHK = 9'b000010000,
        S_EMIT_SEL = 9'b000100000,
        S_EMIT_OUT = 9'b001000000,
        S_OVF      = 9'b010000000,
        S_WRITE    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [15:0] group_mask_reg;
    logic [15:0] plain_mask_reg;
    logic [15:0] cipher_mask_reg;
    mcpf_pkg::masks_t masks;

    // The request being worked on.
    logic [63:0] plain_reg;
    logic [63:0] cipher_reg;
    logic [31:0] fold_reg;
    logic [63:0] key_in;

    // Sequencer bookkeeping.
    logic [WB-1:0]                  way_reg, way_next;
    logic [WAYS-1:0]                match_reg, match_next;
    logic                           free_found_reg, free_found_next;
    logic [WB-1:0]                  free_way_reg, free_way_next;
    logic                           start_reg, start_next;
    logic                           pending_reg, pending_next;
    logic [mcpf_pkg::EPOCH_W-1:0]   epoch_reg, epoch_next;
    logic [ADDR_W-1:0]              clr_reg, clr_next;
    logic [WB-1:0]                  first_way;
    logic [WB-1:0]                  rd_way;
    logic [WAYS-1:0]                sel_mask;

    // Set index unit.
    logic              hash_done;
    logic [SIDX_W-1:0] set_idx;

    // Memory ports.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    mcpf_pkg::entry_t  mem_wdata;
    mcpf_pkg::entry_t  mem_rdata;

    // Matcher results.
    logic entry_live;
    logic entry_hit;

    // Output register.
    logic        m_valid_reg;
    logic        slot_free;
    logic        out_load;
    logic        out_ovf;
    logic        out_last;
    logic [63:0] out_sp;
    logic [63:0] out_sc;
    logic [63:0] m_sp_reg;
    logic [63:0] m_sc_reg;
    logic [63:0] m_np_reg;
    logic [63:0] m_nc_reg;
    logic        m_ovf_reg;
    logic        m_last_reg;

    // ------------------------------------------------------------------------
    // Configuration. The user must write only while idle (not enforced), so the
    // masks are steady for the whole life of a request. Unknown indexes are ignored.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            group_mask_reg  <= mcpf_pkg::GROUP_MASK_RST;
            plain_mask_reg  <= mcpf_pkg::PLAIN_MASK_RST;
            cipher_mask_reg <= mcpf_pkg::CIPHER_MASK_RST;
        end else if (cfg_wen) begin
            case (cfg_idx)
                mcpf_pkg::CFG_GROUP_MASK:  group_mask_reg  <= cfg_wdata;
                mcpf_pkg::CFG_PLAIN_MASK:  plain_mask_reg  <= cfg_wdata;
                mcpf_pkg::CFG_CIPHER_MASK: cipher_mask_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign masks.group_bits = mcpf_pkg::nibble_expand(group_mask_reg);
    assign masks.plain_nib  = plain_mask_reg;
    assign masks.cipher_nib = cipher_mask_reg;

    // The hash key is the ciphertext cut to its group nibbles, folded to 32
    // bits. It is captured together with the request.
    assign key_in = s_cipher_word & masks.group_bits;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            plain_reg  <= s_plain_word;
            cipher_reg <= s_cipher_word;
            fold_reg   <= key_in[63:32] ^ key_in[31:0];
        end
    end

    // ------------------------------------------------------------------------
    // Datapath parts: set index reduction, pair memory and the one shared
    // comparator that checks every way in turn.
    // ------------------------------------------------------------------------
    mcpf_setmod #(
        .SETS   (SETS),
        .SIDX_W (SIDX_W)
    ) u_setmod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (start_reg),
        .dividend (fold_reg),
        .done     (hash_done),
        .set_idx  (set_idx)
    );

    mcpf_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr ({set_idx, rd_way}),
        .rdata (mem_rdata)
    );

    mcpf_match u_match (
        .entry      (mem_rdata),
        .epoch      (epoch_reg),
        .new_plain  (plain_reg),
        .new_cipher (cipher_reg),
        .masks      (masks),
        .live       (entry_live),
        .hit        (entry_hit)
    );

    // Lowest way still flagged as a match; results go out in way order.
    always_comb begin
        first_way = '0;
        for (int i = WAYS - 1; i >= 0; i--) begin
            if (match_reg[i]) begin
                first_way = WB'(i);
            end
        end
    end

    assign sel_mask  = WAYS'(1) << way_reg;
    assign slot_free = !m_valid_reg || m_ready;
    assign s_ready   = (state_reg == S_IDLE);

    // ------------------------------------------------------------------------
    // Sequencer. A request runs through: set index, a scan that reads each
    // way and records matches and the first free way, an emit pass that
    // rereads each matching way and sends it out, then either the write of
    // the new pair or the overflow status result.
    // A first-of-structure request bumps the structure counter, which makes
    // every older entry dead at once; when the counter would wrap, a full
    // clearing pass runs first so no stale entry can come back to life.
    // ------------------------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        way_next        = way_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        free_way_next   = free_way_reg;
        start_next      = 1'b0;
        pending_next    = pending_reg;
        epoch_next      = epoch_reg;
        clr_next        = clr_reg;
        rd_way          = way_reg;
        mem_we          = 1'b0;
        mem_waddr       = {set_idx, free_way_reg};
        mem_wdata.valid  = 1'b1;
        mem_wdata.epoch  = epoch_reg;
        mem_wdata.plain  = plain_reg;
        mem_wdata.cipher = cipher_reg;
        out_load        = 1'b0;
        out_ovf         = 1'b0;
        out_last        = 1'b0;
        out_sp          = mem_rdata.plain;
        out_sc          = mem_rdata.cipher;

        case (state_reg)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == '1) begin
                    if (pending_reg) begin
                        pending_next = 1'b0;
                        start_next   = 1'b1;
                        state_next   = S_HASH;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    way_next        = '0;
                    match_next      = '0;
                    free_found_next = 1'b0;
                    if (s_first_of_structure && (epoch_reg == '1)) begin
                        epoch_next   = '0;
                        pending_next = 1'b1;
                        state_next   = S_CLEAR;
                    end else begin
                        if (s_first_of_structure) begin
                            epoch_next = epoch_reg + mcpf_pkg::EPOCH_W'(1);
                        end
                        start_next = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            S_HASH: begin
                if (hash_done) begin
                    state_next = S_SCAN_RD;
                end
            end

            S_SCAN_RD: begin
                state_next = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                if (!entry_live && !free_found_reg) begin
                    free_found_next = 1'b1;
                    free_way_next   = way_reg;
                end
                if (entry_hit) begin
                    match_next = match_reg | sel_mask;
                end
                if (way_reg == WB'(WAYS - 1)) begin
                    state_next = S_EMIT_SEL;
                end else begin
                    way_next   = way_reg + WB'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_EMIT_SEL: begin
                if (match_reg != '0) begin
                    rd_way     = first_way;
                    way_next   = first_way;
                    state_next = S_EMIT_OUT;
                end else if (free_found_reg) begin
                    state_next = S_WRITE;
                end else begin
                    state_next = S_OVF;
                end
            end

            S_EMIT_OUT: begin
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_last   = ((match_reg & ~sel_mask) == '0) && free_found_reg;
                    match_next = match_reg & ~sel_mask;
                    state_next = S_EMIT_SEL;
                end
            end

            S_OVF: begin
                out_sp = '0;
                out_sc = '0;
                if (slot_free) begin
                    out_load   = 1'b1;
                    out_ovf    = 1'b1;
                    out_last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            S_WRITE: begin
                mem_we     = 1'b1;
                state_next = S_IDLE;
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            way_reg        <= '0;
            match_reg      <= '0;
            free_found_reg <= 1'b0;
            free_way_reg   <= '0;
            start_reg      <= 1'b0;
            pending_reg    <= 1'b0;
            epoch_reg      <= '0;
            clr_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            way_reg        <= way_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            free_way_reg   <= free_way_next;
            start_reg      <= start_next;
            pending_reg    <= pending_next;
            epoch_reg      <= epoch_next;
            clr_reg        <= clr_next;
        end
    end

    // ------------------------------------------------------------------------
    // Output register. It keeps a finished result while the sequencer goes
    // on, so the next request can be taken while the last result waits.
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_sp_reg   <= out_sp;
            m_sc_reg   <= out_sc;
            m_np_reg   <= plain_reg;
            m_nc_reg   <= cipher_reg;
            m_ovf_reg  <= out_ovf;
            m_last_reg <= out_last;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_stored_plain  = m_sp_reg;
    assign m_stored_cipher = m_sc_reg;
    assign m_new_plain     = m_np_reg;
    assign m_new_cipher    = m_nc_reg;
    assign m_overflow      = m_ovf_reg;
    assign m_last_of_run   = m_last_reg;

    // ------------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------------

    // A result is never loaded over one that has not been taken.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> slot_free)
        else $error("result loaded while output register still full");

    // The overflow status is always the closing result of its request.
    a_ovf_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_overflow) |-> m_last_of_run)
        else $error("overflow result not marked last");

    // The new pair is only written to a way found free during the scan.
    a_write_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> (free_found_reg && (match_reg == '0)))
        else $error("store write without a free way or with matches pending");

    // After a request is taken, no second one is taken in the next cycle.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one still in work");

endmodule

@@ hdl/mcpf_setmod.sv @@
// ----------------------------------------------------------------------------
// mcpf_setmod: set index from the folded key
// Reduces a 32-bit value modulo SETS; a mask for powers of two, otherwise a
// reciprocal multiply and one compare and subtract.
// ----------------------------------------------------------------------------
module mcpf_setmod #(
    parameter int SETS   = 1024,
    parameter int SIDX_W = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [31:0]       dividend,
    output logic              done,
    output logic [SIDX_W-1:0] set_idx
);

    generate
        if ((SETS & (SETS - 1)) == 0) begin : g_mask
            logic              done_reg;
            logic [SIDX_W-1:0] idx_reg;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    idx_reg <= SIDX_W'(dividend & 32'(SETS - 1));
                end
            end

            assign done    = done_reg;
            assign set_idx = idx_reg;
        end else begin : g_recip
            // The reciprocal is rounded down, so the quotient estimate is the
            // true quotient or one less, and the first remainder is below
            // twice SETS. One compare and subtract then finishes the job.
            localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / 64'(SETS));
            localparam logic [31:0] SETS_W = 32'(SETS);
            localparam int          RW     = SIDX_W + 1;

            logic              q_vld_reg;
            logic              r_vld_reg;
            logic              done_reg;
            logic [31:0]       num_reg;
            logic [31:0]       quo_reg;
            logic [RW-1:0]     rem_reg;
            logic [SIDX_W-1:0] idx_reg;
            logic [63:0]       prod;
            logic [31:0]       diff;

            assign prod = {32'h0, dividend} * {32'h0, RECIP};
            assign diff = num_reg - (quo_reg * SETS_W);

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    q_vld_reg <= 1'b0;
                    r_vld_reg <= 1'b0;
                    done_reg  <= 1'b0;
                end else begin
                    q_vld_reg <= start;
                    r_vld_reg <= q_vld_reg;
                    done_reg  <= r_vld_reg;
                end
            end

            always_ff @(posedge aclk) begin
                if (start) begin
                    num_reg <= dividend;
                    quo_reg <= prod[63:32];
                end
                if (q_vld_reg) begin
                    rem_reg <= diff[RW-1:0];
                end
                if (r_vld_reg) begin
                    idx_reg <= (rem_reg >= RW'(SETS)) ? SIDX_W'(rem_reg - RW'(SETS))
                                                      : rem_reg[SIDX_W-1:0];
                end
            end

            assign done    = done_reg;
            assign set_idx = idx_reg;
        end
    endgenerate

endmodule

@@ hdl/mcpf_store.sv @@
// ----------------------------------------------------------------------------
// mcpf_store: pair memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module mcpf_store #(
    parameter int ADDR_W = 13
) (
    input  logic                  aclk,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     waddr,
    input  mcpf_pkg::entry_t      wdata,
    input  logic [ADDR_W-1:0]     raddr,
    output mcpf_pkg::entry_t      rdata
);

    mcpf_pkg::entry_t mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/mcpf_match.sv @@
// ----------------------------------------------------------------------------
// mcpf_match: shared pair comparator
// Decides whether one stored entry is live and whether it pairs with the
// new item; used once per way during the set scan.
// ----------------------------------------------------------------------------
module mcpf_match (
    input  mcpf_pkg::entry_t                entry,
    input  logic [mcpf_pkg::EPOCH_W-1:0]    epoch,
    input  logic [63:0]                     new_plain,
    input  logic [63:0]                     new_cipher,
    input  mcpf_pkg::masks_t                masks,
    output logic                            live,
    output logic                            hit
);

    logic group_eq;

    assign live     = entry.valid && (entry.epoch == epoch);
    assign group_eq = ((entry.cipher ^ new_cipher) & masks.group_bits) == 64'h0;
    assign hit      = live && group_eq
                   && mcpf_pkg::all_differ(entry.plain, new_plain, masks.plain_nib)
                   && mcpf_pkg::all_differ(entry.cipher, new_cipher, masks.cipher_nib);

endmodule

@@ tb/sv/tb_masked_collision_pair_finder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_masked_collision_pair_finder_core: self-checking bench of the pair finder
// Streams plaintext/ciphertext pairs through the core and checks every
// collision report against an in-bench model of the set-associative store
// or a typed-in answer. The model covers matching, set overflow and structure
// clears. A short directed table comes first, then random structures under
// several mask settings, with random gaps on the request side and random
// stalls on the report side.
// ----------------------------------------------------------------------------
module tb_masked_collision_pair_finder_core;

    localparam int SETS = 1024;
    localparam int WAYS = 8;

    // The core clears all 8192 entries of its store after reset and again
    // every 256 structures. No request is taken during that pass, so the
    // watchdog has to tolerate it several times over.
    localparam int QUIET_LIMIT = 40000;

    // Random requests per mask setting.
    localparam int ITEMS_PER_PHASE = 60;

    // Register index that the core decodes to nothing.
    localparam logic [mcpf_pkg::CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

    localparam logic [63:0] ZERO_WORD = 64'h0000_0000_0000_0000;
    localparam logic [63:0] ONES_WORD = 64'hFFFF_FFFF_FFFF_FFFF;
    // Nibble expansions of the reset group mask and of its complement. Under
    // the reset masks the cipher differ nibbles are exactly the non-group
    // nibbles, which makes the expected reports of some rows easy to see.
    localparam logic [63:0] GROUP_NIBS = 64'hF00F_00FF_0FF0_FF00;
    localparam logic [63:0] OTHER_NIBS = 64'h0FF0_FF00_F00F_00FF;

    // How a directed row is checked: against the model, or against a
    // typed-in answer of no report or of one match with a known earlier pair.
    typedef enum logic [1:0] {
        CHK_BY_MODEL,
        CHK_NO_REPORT,
        CHK_ONE_MATCH
    } check_t;

    typedef struct {
        logic [63:0] stored_plain;
        logic [63:0] stored_cipher;
        logic [63:0] new_plain;
        logic [63:0] new_cipher;
        logic        overflow;
        logic        last_of_run;
    } collision_t;

    typedef struct {
        logic [63:0] plain;
        logic [63:0] cipher;
        logic        first;
        check_t      how;
        logic [63:0] prior_plain;
        logic [63:0] prior_cipher;
    } stim_row_t;

    localparam int DIR_ROWS = 22;

    // Directed table, walked under the reset masks.
    stim_row_t directed_rows [DIR_ROWS] = '{
        // A fresh structure with an empty store gives nothing.
        '{ZERO_WORD, ZERO_WORD, 1'b1, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        // Same group key as the zero pair and every selected nibble differs.
        '{ONES_WORD, OTHER_NIBS, 1'b0, CHK_ONE_MATCH, ZERO_WORD, ZERO_WORD},
        // The twin of the previous pair is not a partner of it.
        '{ONES_WORD, OTHER_NIBS, 1'b0, CHK_ONE_MATCH, ZERO_WORD, ZERO_WORD},
        // Fill the rest of set zero.
        '{64'h1, ZERO_WORD, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        '{64'h2, ZERO_WORD, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        '{64'h3, ZERO_WORD, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        '{64'h4, ZERO_WORD, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        '{64'h5, ZERO_WORD, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        // Set zero is full: matches followed by the overflow report.
        '{ONES_WORD, OTHER_NIBS, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        // Clearing the structure empties the store again.
        '{ZERO_WORD, ZERO_WORD, 1'b1, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        // Seven identical pairs never pair with one another.
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        '{ZERO_WORD, ZERO_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        // Eight matches plus the overflow report: the longest run.
        '{ONES_WORD, OTHER_NIBS, 1'b0, CHK_BY_MODEL, ZERO_WORD, ZERO_WORD},
        // All-ones cipher folds to the top set, which is still empty.
        '{ONES_WORD, ONES_WORD, 1'b0, CHK_NO_REPORT, ZERO_WORD, ZERO_WORD},
        // Same group nibbles, everything else flipped.
        '{ZERO_WORD, GROUP_NIBS, 1'b0, CHK_ONE_MATCH, ONES_WORD, ONES_WORD},
        '{64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, 1'b0, CHK_BY_MODEL,
          ZERO_WORD, ZERO_WORD},
        '{64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1, CHK_BY_MODEL,
          ZERO_WORD, ZERO_WORD}
    };

    // ------------------------------------------------------------------------
    // DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------------
    logic                           aclk                 = 1'b0;
    logic                           aresetn              = 1'b0;
    logic                           cfg_wen              = 1'b0;
    logic [mcpf_pkg::CFG_IDX_W-1:0] cfg_idx              = '0;
    logic [15:0]                    cfg_wdata            = '0;
    logic                           s_valid              = 1'b0;
    logic                           s_ready;
    logic [63:0]                    s_plain_word         = '0;
    logic [63:0]                    s_cipher_word        = '0;
    logic                           s_first_of_structure = 1'b0;
    logic                           m_valid;
    logic                           m_ready              = 1'b0;
    logic [63:0]                    m_stored_plain;
    logic [63:0]                    m_stored_cipher;
    logic [63:0]                    m_new_plain;
    logic [63:0]                    m_new_cipher;
    logic                           m_overflow;
    logic                           m_last_of_run;

    // Check mode and typed-in partner travel with each request.
    check_t               req_how          = CHK_BY_MODEL;
    logic [63:0]          req_prior_plain  = '0;
    logic [63:0]          req_prior_cipher = '0;

    masked_collision_pair_finder_core #(
        .SETS (SETS),
        .WAYS (WAYS)
    ) u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_wen              (cfg_wen),
        .cfg_idx              (cfg_idx),
        .cfg_wdata            (cfg_wdata),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_plain_word         (s_plain_word),
        .s_cipher_word        (s_cipher_word),
        .s_first_of_structure (s_first_of_structure),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_stored_plain       (m_stored_plain),
        .m_stored_cipher      (m_stored_cipher),
        .m_new_plain          (m_new_plain),
        .m_new_cipher         (m_new_cipher),
        .m_overflow           (m_overflow),
        .m_last_of_run        (m_last_of_run)
    );

    // 12 ns clock.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Bench model of the pair store and the mask registers.
    // ------------------------------------------------------------------------
    logic [63:0] pair_plain  [SETS*WAYS];
    logic [63:0] pair_cipher [SETS*WAYS];
    bit          pair_live   [SETS*WAYS];
    logic [15:0] mask_group;
    logic [15:0] mask_plain;
    logic [15:0] mask_cipher;

    collision_t  fresh_collisions [$];   // reports caused by the latest request
    collision_t  collisions_due   [$];   // reports still to come, oldest first
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          burst_left     = 0;

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Widen a nibble select mask to one bit per ciphertext bit.
    function automatic logic [63:0] spread_mask(input logic [15:0] sel);
        logic [63:0] bits;
        bits = '0;
        for (int n = 0; n < 16; n++) begin
            if (sel[n]) begin
                bits[4*n +: 4] = 4'hF;
            end
        end
        return bits;
    endfunction

    // True when no selected nibble of the two words is equal.
    function automatic bit differs_everywhere(input logic [63:0] a,
                                              input logic [63:0] b,
                                              input logic [15:0] sel);
        logic [63:0] diff;
        diff = a ^ b;
        for (int n = 0; n < 16; n++) begin
            if (sel[n] && diff[4*n +: 4] == 4'h0) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Clear on a first pair, look the new pair up in its set, collect the partners
    // in way order, then store it in the lowest free way or report the overflow.
    task automatic find_collisions(input logic [63:0] plain,
                                   input logic [63:0] cipher,
                                   input logic        first);
        logic [63:0] gbits;
        logic [63:0] key;
        logic [31:0] fold;
        int unsigned base;
        int unsigned slot;
        int          free_way;
        collision_t  hit;
        gbits    = spread_mask(mask_group);
        key      = cipher & gbits;
        fold     = key[63:32] ^ key[31:0];
        base     = (fold % SETS) * WAYS;
        free_way = -1;
        fresh_collisions.delete();
        if (first) begin
            foreach (pair_live[i]) begin
                pair_live[i] = 1'b0;
            end
        end
        for (int w = 0; w < WAYS; w++) begin
            slot = base + w;
            if (!pair_live[slot]) begin
                if (free_way < 0) begin
                    free_way = w;
                end
            end else if ((pair_cipher[slot] & gbits) == key &&
                         differs_everywhere(pair_plain[slot], plain, mask_plain) &&
                         differs_everywhere(pair_cipher[slot], cipher, mask_cipher)) begin
                hit = '{pair_plain[slot], pair_cipher[slot], plain, cipher, 1'b0, 1'b0};
                fresh_collisions.push_back(hit);
            end
        end
        if (free_way >= 0) begin
            slot              = base + free_way;
            pair_plain[slot]  = plain;
            pair_cipher[slot] = cipher;
            pair_live[slot]   = 1'b1;
        end else begin
            hit = '{ZERO_WORD, ZERO_WORD, plain, cipher, 1'b1, 1'b0};
            fresh_collisions.push_back(hit);
        end
        if (fresh_collisions.size() > 0) begin
            fresh_collisions[fresh_collisions.size()-1].last_of_run = 1'b1;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatch_count++;
        $display("%0t MISMATCH %s: got %h, want %h", $realtime, what, got, want);
    endtask

    // Compare one accepted report with the oldest one still due.
    task automatic check_report();
        collision_t want;
        if (collisions_due.size() == 0) begin
            flag_mismatch("report with none due, new_plain", m_new_plain, ZERO_WORD);
            return;
        end
        want = collisions_due.pop_front();
        if (m_stored_plain !== want.stored_plain)
            flag_mismatch("stored_plain", m_stored_plain, want.stored_plain);
        if (m_stored_cipher !== want.stored_cipher)
            flag_mismatch("stored_cipher", m_stored_cipher, want.stored_cipher);
        if (m_new_plain !== want.new_plain)
            flag_mismatch("new_plain", m_new_plain, want.new_plain);
        if (m_new_cipher !== want.new_cipher)
            flag_mismatch("new_cipher", m_new_cipher, want.new_cipher);
        if (m_overflow !== want.overflow)
            flag_mismatch("overflow", 64'(m_overflow), 64'(want.overflow));
        if (m_last_of_run !== want.last_of_run)
            flag_mismatch("last_of_run", 64'(m_last_of_run), 64'(want.last_of_run));
    endtask

    // ------------------------------------------------------------------------
    // Monitor. Everything is sampled at the rising edge, where the core's
    // outputs still hold their pre-edge values. Register writes, accepted
    // requests and accepted reports all update the model here, so the model
    // follows exactly what the core saw.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            mask_group   = mcpf_pkg::GROUP_MASK_RST;
            mask_plain   = mcpf_pkg::PLAIN_MASK_RST;
            mask_cipher  = mcpf_pkg::CIPHER_MASK_RST;
            quiet_cycles = 0;
            foreach (pair_live[i]) begin
                pair_live[i] = 1'b0;
            end
        end else begin
            if (cfg_wen) begin
                case (cfg_idx)
                    mcpf_pkg::CFG_GROUP_MASK:  mask_group  = cfg_wdata;
                    mcpf_pkg::CFG_PLAIN_MASK:  mask_plain  = cfg_wdata;
                    mcpf_pkg::CFG_CIPHER_MASK: mask_cipher = cfg_wdata;
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                // The model always runs so that the store stays in step; a
                // typed-in row replaces its answer with the one in the table.
                find_collisions(s_plain_word, s_cipher_word, s_first_of_structure);
                case (req_how)
                    CHK_BY_MODEL: begin
                        foreach (fresh_collisions[i]) begin
                            collisions_due.push_back(fresh_collisions[i]);
                        end
                    end
                    CHK_ONE_MATCH: begin
                        collisions_due.push_back('{req_prior_plain, req_prior_cipher,
                                                   s_plain_word, s_cipher_word,
                                                   1'b0, 1'b1});
                    end
                    default: ;
                endcase
            end

            if (m_valid && m_ready) begin
                check_report();
            end

            // Watchdog: a run of cycles without any handshake means a hang.
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t watchdog: no handshake for %0d cycles, %0d reports due",
                         $realtime, QUIET_LIMIT, collisions_due.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Report side. The stall style is redrawn after each random span: always
    // ready, coin-flip ready, or mostly stalled.
    // ------------------------------------------------------------------------
    int stall_style = 0;
    int stall_span  = 0;

    always @(negedge aclk) begin
        if (stall_span == 0) begin
            stall_style = $urandom_range(0, 2);
            stall_span  = $urandom_range(20, 80);
        end
        stall_span--;
        case (stall_style)
            0:       m_ready <= 1'b1;
            1:       m_ready <= ($urandom_range(0, 1) == 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------------
    // Request side. All drive tasks run on the falling edge.
    // ------------------------------------------------------------------------

    // Offer one request and return at the falling edge after it is taken.
    // Requests come in bursts; a burst may follow the last one directly, or
    // after a short gap with valid low.
    task automatic push_request(input logic [63:0] plain, input logic [63:0] cipher,
                                input logic first, input check_t how,
                                input logic [63:0] prior_plain,
                                input logic [63:0] prior_cipher);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_plain_word         <= plain;
        s_cipher_word        <= cipher;
        s_first_of_structure <= first;
        req_how              <= how;
        req_prior_plain      <= prior_plain;
        req_prior_cipher     <= prior_cipher;
        s_valid              <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // Stop sending until every due report has been taken and the core is
    // back to idle with its output register empty. A request that produces
    // no report, or one that waits on a clearing pass, is finished as well.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        while (collisions_due.size() != 0 || !s_ready || m_valid) @(negedge aclk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [mcpf_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [15:0] value);
        cfg_wen   <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
    endtask

    // Masks change only with the core idle. The unused index is poked once
    // to show that it changes nothing.
    task automatic load_masks(input logic [15:0] group, input logic [15:0] plain,
                              input logic [15:0] cipher, input bit poke_spare);
        hold_until_drained();
        write_register(mcpf_pkg::CFG_GROUP_MASK, group);
        write_register(mcpf_pkg::CFG_PLAIN_MASK, plain);
        write_register(mcpf_pkg::CFG_CIPHER_MASK, cipher);
        if (poke_spare) begin
            write_register(CFG_SPARE_IDX, 16'($urandom_range(0, 16'hFFFF)));
        end
        cfg_wen <= 1'b0;
        @(negedge aclk);
    endtask

    // Random structures. Most pairs of a structure share the group nibbles
    // of one of a few seeds, so they land in the same set and can match or
    // overflow it. A tenth are stray ciphertexts, and now and then a
    // structure carries on without a clear or is cut by a stray clear.
    task automatic run_structures(input int count);
        logic [63:0] seeds [3];
        logic [63:0] gbits;
        logic [63:0] cipher;
        logic        first;
        int          len;
        int          n_seeds;
        int          sent;
        sent  = 0;
        gbits = spread_mask(mask_group);
        while (sent < count) begin
            len     = $urandom_range(1, 14);
            n_seeds = $urandom_range(1, 3);
            foreach (seeds[k]) begin
                seeds[k] = random_word();
            end
            for (int i = 0; i < len && sent < count; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    cipher = random_word();
                end else begin
                    cipher = (seeds[$urandom_range(0, n_seeds-1)] & gbits) |
                             (random_word() & ~gbits);
                end
                if (i == 0) begin
                    first = ($urandom_range(0, 9) != 0);
                end else begin
                    first = ($urandom_range(0, 49) == 0);
                end
                push_request(random_word(), cipher, first, CHK_BY_MODEL,
                             ZERO_WORD, ZERO_WORD);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] rnd_group;

        // Hold reset, then release it on a falling edge.
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed rows under the reset masks. The core is still clearing
        // its store; the first request simply waits for ready.
        foreach (directed_rows[r]) begin
            push_request(directed_rows[r].plain, directed_rows[r].cipher,
                         directed_rows[r].first, directed_rows[r].how,
                         directed_rows[r].prior_plain, directed_rows[r].prior_cipher);
        end

        // Empty masks: every pair is one group in set zero and matches all.
        load_masks(16'h0000, 16'h0000, 16'h0000, 1'b1);
        run_structures(ITEMS_PER_PHASE);

        // Full group mask: only identical ciphertexts pair up, and no cipher
        // nibble has to differ.
        load_masks(16'hFFFF, 16'hFFFF, 16'h0000, 1'b0);
        run_structures(ITEMS_PER_PHASE);

        load_masks(mcpf_pkg::GROUP_MASK_RST, mcpf_pkg::PLAIN_MASK_RST,
                   mcpf_pkg::CIPHER_MASK_RST, 1'b0);
        run_structures(ITEMS_PER_PHASE);

        // Random group mask with the cipher differ nibbles all outside it.
        rnd_group = 16'($urandom_range(0, 16'hFFFF));
        load_masks(rnd_group, 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)) & ~rnd_group, 1'b0);
        run_structures(ITEMS_PER_PHASE);

        // Empty group mask with random differ masks.
        load_masks(16'h0000, 16'($urandom_range(0, 16'hFFFF)),
                   16'($urandom_range(0, 16'hFFFF)), 1'b0);
        run_structures(ITEMS_PER_PHASE);

        // Wait out the last reports; a stray one left in the output register
        // is taken and caught by the monitor as a report with none due.
        hold_until_drained();
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
